/* hw/rtl/bfiq_pkg.sv */
// Shared types and constants for the Bloom filter insert/query block.
// Used by the controller, the datapath and the top level; no dependencies.
package bfiq_pkg;

    localparam int MAP_BITS   = 200;
    localparam int MAX_HASHES = 8;
    localparam int HASH_RANGE = 100;
    localparam int KEY_MUL    = 31;
    localparam int SEED_STEP  = 17;

    localparam int KEY_W   = 24;
    localparam int HC_W    = 4;
    localparam int HC_RST  = 3;
    localparam int POS_W   = $clog2(HASH_RANGE);
    localparam int ADDR_W  = $clog2(MAP_BITS);
    localparam int IDX_W   = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int CNT_W   = $clog2(MAX_HASHES + 1);
    localparam int DIGIT_W = 4;
    localparam int DIGITS  = KEY_W / DIGIT_W;
    localparam int DIG_CW  = $clog2(DIGITS);

    typedef enum logic [2:0] {
        DP_HOLD,
        DP_LOAD,
        DP_DIGIT,
        DP_SCALE,
        DP_NEXT,
        DP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   ram_rd;
        logic   ram_wr;
        logic   wr_bit;
    } dp_cmd_t;

    typedef struct packed {
        logic rd_bit;
        logic clr_last;
    } dp_stat_t;

endpackage

/* hw/rtl/bfiq_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module bfiq_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/bfiq_datapath.sv */
// Datapath: key reduction modulo the hash range, probe position stepping,
// filter bitmap RAM and its clearing address. Depends on bfiq_pkg, bfiq_ram.
module bfiq_datapath
    import bfiq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    input  logic [KEY_W-1:0] key_in,
    output dp_stat_t         stat
);

    localparam int MOD_W   = 12;
    localparam int RECIP   = 1311;   // ceil(2^17 / 100), exact for inputs below 4096
    localparam int RSHIFT  = 17;
    localparam int PROD_W  = 23;
    localparam int Q_W     = PROD_W - RSHIFT;

    // Remainder by the hash range through a reciprocal multiply.
    function automatic logic [POS_W-1:0] mod_range(input logic [MOD_W-1:0] v);
        logic [PROD_W-1:0] prod;
        logic [Q_W-1:0]    q;
        logic [MOD_W-1:0]  r;
        prod = PROD_W'(v) * PROD_W'(RECIP);
        q    = prod[PROD_W-1:RSHIFT];
        r    = v - MOD_W'(q) * MOD_W'(HASH_RANGE);
        return r[POS_W-1:0];
    endfunction

    logic [KEY_W-1:0]  key_reg;
    logic [POS_W-1:0]  rem_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic [MOD_W-1:0]  mod_in;
    logic [POS_W-1:0]  mod_out;
    logic [POS_W:0]    step_sum;
    logic [POS_W-1:0]  pos_next;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_rdata;

    always_comb
    begin
        if (cmd.op == DP_DIGIT)
        begin
            mod_in = (MOD_W'(rem_reg) << DIGIT_W) + MOD_W'(key_reg[KEY_W-1 -: DIGIT_W]);
        end
        else
        begin
            mod_in = MOD_W'(rem_reg) * MOD_W'(KEY_MUL);
        end
    end

    assign mod_out = mod_range(mod_in);

    always_comb
    begin
        step_sum = (POS_W+1)'(pos_reg) + (POS_W+1)'(SEED_STEP);
        if (step_sum >= (POS_W+1)'(HASH_RANGE))
        begin
            step_sum = step_sum - (POS_W+1)'(HASH_RANGE);
        end
        pos_next = step_sum[POS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LOAD:
            begin
                key_reg <= key_in;
                rem_reg <= '0;
            end
            DP_DIGIT:
            begin
                key_reg <= key_reg << DIGIT_W;
                rem_reg <= mod_out;
            end
            DP_SCALE: pos_reg <= mod_out;
            DP_NEXT:  pos_reg <= pos_next;
            DP_HOLD, DP_CLEAR:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.op == DP_CLEAR)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Positions stay below the hash range, which never exceeds the map size.
    assign ram_addr = (cmd.op == DP_CLEAR) ? clr_addr_reg : ADDR_W'(pos_reg);

    bfiq_ram #(
        .WIDTH(1),
        .DEPTH(MAP_BITS)
    ) u_map (
        .clk  (clk),
        .we   (cmd.ram_wr),
        .re   (cmd.ram_rd),
        .addr (ram_addr),
        .wdata(cmd.wr_bit),
        .rdata(ram_rdata)
    );

    assign stat.rd_bit   = ram_rdata;
    assign stat.clr_last = (clr_addr_reg == ADDR_W'(MAP_BITS - 1));

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op != DP_CLEAR && (cmd.ram_rd || cmd.ram_wr)) |-> pos_reg < POS_W'(HASH_RANGE))
        else $error("probe position outside hash range");

    a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_CLEAR) |-> (cmd.ram_wr && !cmd.wr_bit))
        else $error("clearing pass must write zeros");

endmodule

/* hw/rtl/bfiq_ctrl.sv */
// Controller state machine: clearing pass, key reduction steps, probe loop
// and result hand-off. Depends on bfiq_pkg.
module bfiq_ctrl
    import bfiq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             is_query,
    input  logic [CNT_W-1:0] hash_n,
    input  logic             out_free,
    input  dp_stat_t         stat,
    output dp_cmd_t          cmd,
    output logic             idle,
    output logic             done,
    output logic             result
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIGIT,
        ST_SCALE,
        ST_INS,
        ST_QRD,
        ST_QCHK,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [DIG_CW-1:0] dig_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              query_reg;
    logic              result_reg;
    logic              last_idx;

    assign last_idx = ((CNT_W'(idx_reg) + 1'b1) == hash_n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            dig_reg    <= '0;
            idx_reg    <= '0;
            query_reg  <= 1'b0;
            result_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (stat.clr_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        query_reg <= is_query;
                        dig_reg   <= '0;
                        idx_reg   <= '0;
                        state_reg <= ST_DIGIT;
                    end
                end
                ST_DIGIT:
                begin
                    dig_reg <= dig_reg + 1'b1;
                    if (dig_reg == DIG_CW'(DIGITS - 1))
                    begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    if (hash_n == '0)
                    begin
                        // Nothing to probe: a query finds no clear bit.
                        result_reg <= query_reg;
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= query_reg ? ST_QRD : ST_INS;
                    end
                end
                ST_INS:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (last_idx)
                    begin
                        result_reg <= 1'b0;
                        state_reg  <= ST_DONE;
                    end
                end
                ST_QRD:
                begin
                    state_reg <= ST_QCHK;
                end
                ST_QCHK:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (!stat.rd_bit)
                    begin
                        result_reg <= 1'b0;
                        state_reg  <= ST_DONE;
                    end
                    else if (last_idx)
                    begin
                        result_reg <= 1'b1;
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_QRD;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd.op     = DP_HOLD;
        cmd.ram_rd = 1'b0;
        cmd.ram_wr = 1'b0;
        cmd.wr_bit = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op     = DP_CLEAR;
                cmd.ram_wr = 1'b1;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op = DP_LOAD;
                end
            end
            ST_DIGIT: cmd.op = DP_DIGIT;
            ST_SCALE: cmd.op = DP_SCALE;
            ST_INS:
            begin
                cmd.op     = DP_NEXT;
                cmd.ram_wr = 1'b1;
                cmd.wr_bit = 1'b1;
            end
            ST_QRD:  cmd.ram_rd = 1'b1;
            ST_QCHK: cmd.op = DP_NEXT;
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign idle   = (state_reg == ST_IDLE);
    assign done   = (state_reg == ST_DONE) && out_free;
    assign result = result_reg;

    a_query_never_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ram_wr && cmd.wr_bit) |-> !query_reg)
        else $error("a query wrote the filter bitmap");

    a_insert_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !query_reg) |-> !result_reg)
        else $error("insert reported a nonzero result");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (idle && start) |=> !idle)
        else $error("controller stayed idle after taking an item");

endmodule

/* hw/rtl/bloom_filter_insert_query_top.sv */
// Top level of the Bloom filter insert/query block: stream ports, hash count
// register and output register. Depends on bfiq_pkg, bfiq_ctrl, bfiq_datapath.
//
//  Channel  Direction  Beat contents
//  s_*      in         tdata[23:0] key, tuser[0] opcode (0 insert, 1 query)
//  m_*      out        tdata[0] maybe_present, tdata[7:1] zero
//  cfg_*    in         cfg_data[3:0] hash_count
//
// From acceptance to result an insert runs six key digit steps, one scaling
// step, then one bitmap access per probe, with n probes where n is the hash
// count saturated at 8; a query adds a read step per probe and may end early.
// After reset a clearing pass of the bitmap runs before s_tready rises.
// A finished result waits in the output register; the next beat is taken
// while it waits, and the block only stalls when a second result is ready.
module bloom_filter_insert_query_top
    import bfiq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] key
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] maybe_present, [7:1] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // [3:0] hash_count
);

    logic [HC_W-1:0]  hc_reg;
    logic [CNT_W-1:0] hash_n;
    logic             out_valid_reg;
    logic             out_bit_reg;
    logic             accept;
    logic             out_free;
    logic             idle;
    logic             done;
    logic             result;
    dp_cmd_t          cmd;
    dp_stat_t         stat;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = idle;
    assign out_free  = !out_valid_reg || m_tready;

    assign hash_n = (hc_reg > HC_W'(MAX_HASHES)) ? CNT_W'(MAX_HASHES) : CNT_W'(hc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg <= HC_W'(HC_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            hc_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_bit_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_bit_reg};

    bfiq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .is_query(s_tuser[0]),
        .hash_n  (hash_n),
        .out_free(out_free),
        .stat    (stat),
        .cmd     (cmd),
        .idle    (idle),
        .done    (done),
        .result  (result)
    );

    bfiq_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .key_in(s_tdata[KEY_W-1:0]),
        .stat  (stat)
    );

endmodule
